[sv/ttms_pkg.sv]
// Shared types and constants for the tail time makespan scheduler.
package ttms_pkg;

    // Default parameter values.
    localparam int MAX_ITEMS_DEF = 64;
    localparam int TIME_BITS_DEF = 16;

    // Field widths of the requests and results.
    localparam int IN_TIME_W  = 16;
    localparam int MAKESPAN_W = 23;
    localparam logic [MAKESPAN_W-1:0] MAKESPAN_MAX = {MAKESPAN_W{1'b1}};

    // One input request: a job of the batch.
    typedef struct packed {
        logic [IN_TIME_W-1:0] heat_time;
        logic [IN_TIME_W-1:0] eat_time;
        logic                 last_item;
    } in_req_t;

    // One result: the makespan of a finished batch.
    typedef struct packed {
        logic [MAKESPAN_W-1:0] makespan;
        logic                  overflow;
    } out_res_t;

    // Operation that all cells of the chain perform in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } cell_op_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

[sv/ttms_cell.sv]
// One cell of the sorted job chain: holds a single job and trades it with its neighbors.
module ttms_cell import ttms_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  cell_ctrl_t           ctrl,
    input  logic                 occupied,
    input  logic [TIME_BITS-1:0] new_heat,
    input  logic [TIME_BITS-1:0] new_eat,
    input  logic                 left_displace,
    input  logic [TIME_BITS-1:0] left_heat,
    input  logic [TIME_BITS-1:0] left_eat,
    input  logic [TIME_BITS-1:0] right_heat,
    input  logic [TIME_BITS-1:0] right_eat,
    output logic                 displace,
    output logic [TIME_BITS-1:0] heat,
    output logic [TIME_BITS-1:0] eat
);

    logic [TIME_BITS-1:0] heat_reg, heat_next;
    logic [TIME_BITS-1:0] eat_reg, eat_next;

    // The new job goes ahead of this entry if the entry is empty or has a shorter tail.
    // Equal tails keep the stored job in front.
    assign displace = !occupied || (eat_reg < new_eat);

    // Select the next content: keep, take the new job, take the left neighbor's job,
    // or take the right neighbor's job while the chain drains toward the head.
    always_comb begin
        heat_next = heat_reg;
        eat_next  = eat_reg;
        case (ctrl.op)
            CELL_INSERT: begin
                if (displace) begin
                    if (left_displace) begin
                        heat_next = left_heat;
                        eat_next  = left_eat;
                    end else begin
                        heat_next = new_heat;
                        eat_next  = new_eat;
                    end
                end
            end
            CELL_SHIFT: begin
                heat_next = right_heat;
                eat_next  = right_eat;
            end
            default: begin
                heat_next = heat_reg;
                eat_next  = eat_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        heat_reg <= heat_next;
        eat_reg  <= eat_next;
    end

    assign heat = heat_reg;
    assign eat  = eat_reg;

endmodule

[sv/tail_time_makespan_scheduler.sv]
// Top level of the tail time makespan scheduler: cell chain and batch sequencer.
//
//   channel | ports                        | carries
//   --------+------------------------------+-----------------------------------
//   input   | s_valid, s_ready, s_data     | one job: heat, tail, last marker
//   result  | m_valid, m_ready, m_data     | makespan and overflow of a batch
//
// Each job is sorted into the cell chain as it is accepted, so jobs enter back to back.
// After the job marked last, the chain shifts its stored jobs toward its head one by
// one, folding each job into the running completion time; the sequencer then sees the
// count run out and loads the result register, so s_ready stays low in the drain and
// emit states, and longer while an earlier result still waits in the result register.
// A waiting result does not stop a new batch; only a finished second batch waits
// for the result register. Reset clears the state, job count, flags and handshakes only.
module tail_time_makespan_scheduler import ttms_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output out_res_t m_data
);

    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int ACC_RAW = TIME_BITS + CNT_W + 1;
    localparam int ACC_W   = (ACC_RAW > MAKESPAN_W + 1) ? ACC_RAW : MAKESPAN_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic [CNT_W-1:0]     remain_reg, remain_next;
    logic [ACC_W-1:0]     done_reg, done_next;
    logic [ACC_W-1:0]     best_reg, best_next;
    logic                 ovf_reg, ovf_next;
    logic                 m_valid_reg, m_valid_next;
    out_res_t             m_data_reg, m_data_next;

    cell_ctrl_t           ctrl;
    logic                 s_fire;
    logic                 store_full;
    logic                 out_free;
    logic [TIME_BITS-1:0] new_heat;
    logic [TIME_BITS-1:0] new_eat;
    logic [ACC_W-1:0]     finish;

    logic [TIME_BITS-1:0] cell_heat [MAX_ITEMS];
    logic [TIME_BITS-1:0] cell_eat  [MAX_ITEMS];
    logic                 cell_disp [MAX_ITEMS];

    // Request handshake and job fields cut to the working time width.
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign store_full = (count_reg == CNT_W'(MAX_ITEMS));
    assign new_heat   = TIME_BITS'(s_data.heat_time);
    assign new_eat    = TIME_BITS'(s_data.eat_time);
    assign out_free   = !m_valid_reg || m_ready;

    // Chain of cells, head at index zero holding the longest tail.
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        logic                 left_disp;
        logic [TIME_BITS-1:0] left_heat, left_eat;
        logic [TIME_BITS-1:0] right_heat, right_eat;

        if (i == 0) begin : g_head
            assign left_disp = 1'b0;
            assign left_heat = '0;
            assign left_eat  = '0;
        end else begin : g_body
            assign left_disp = cell_disp[i-1];
            assign left_heat = cell_heat[i-1];
            assign left_eat  = cell_eat[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_tail
            assign right_heat = '0;
            assign right_eat  = '0;
        end else begin : g_next
            assign right_heat = cell_heat[i+1];
            assign right_eat  = cell_eat[i+1];
        end

        ttms_cell #(
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .occupied     (CNT_W'(i) < count_reg),
            .new_heat     (new_heat),
            .new_eat      (new_eat),
            .left_displace(left_disp),
            .left_heat    (left_heat),
            .left_eat     (left_eat),
            .right_heat   (right_heat),
            .right_eat    (right_eat),
            .displace     (cell_disp[i]),
            .heat         (cell_heat[i]),
            .eat          (cell_eat[i])
        );
    end

    // Completion time of the head job plus its tail.
    assign finish = done_reg + ACC_W'(cell_heat[0]) + ACC_W'(cell_eat[0]);

    // Batch sequencer: insert jobs, drain the chain, hand out the result.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        remain_next  = remain_reg;
        done_next    = done_reg;
        best_next    = best_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ctrl.op      = CELL_HOLD;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (store_full) begin
                        dropped_next = 1'b1;
                    end else begin
                        ctrl.op    = CELL_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_data.last_item) begin
                        state_next   = ST_DRAIN;
                        remain_next  = count_next;
                        ovf_next     = dropped_next;
                        done_next    = '0;
                        best_next    = '0;
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                end
            end
            ST_DRAIN: begin
                if (remain_reg != '0) begin
                    ctrl.op     = CELL_SHIFT;
                    remain_next = remain_reg - CNT_W'(1);
                    done_next   = done_reg + ACC_W'(cell_heat[0]);
                    if (finish > best_reg) begin
                        best_next = finish;
                    end
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_data_next.overflow = ovf_reg;
                    if (best_reg > ACC_W'(MAKESPAN_MAX)) begin
                        m_data_next.makespan = MAKESPAN_MAX;
                    end else begin
                        m_data_next.makespan = best_reg[MAKESPAN_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        done_reg   <= done_next;
        best_reg   <= best_next;
        ovf_reg    <= ovf_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
